### hw/rtl/p2sg_pkg.sv
package p2sg_pkg;

  // field and working widths
  localparam int PlatoW     = 16;
  localparam int GravW      = 21;
  localparam int OutTdataW  = 24;
  localparam int FracW      = 24;
  localparam int SgW        = 26;   // estimate, Q24, 0..2.0
  localparam int S2W        = 27;   // s^2, Q24, up to 4.0
  localparam int S3W        = 28;   // s^3, Q24, up to 8.0
  localparam int MulW       = 40;   // constant times working value, Q24
  localparam int AccW       = 42;   // signed sums for f and f'
  localparam int DenW       = 36;   // f' magnitude
  localparam int FmagW      = 35;   // |f|
  localparam int NumW       = FmagW + FracW;
  localparam int NewtonQuoW = 27;   // |f/f'| < 8
  localparam int GuessDenW  = 33;
  localparam int GuessNumW  = PlatoW + 38;
  localparam int GuessQuoW  = 23;   // P/denom < 0.5
  localparam int KiW        = 11;
  localparam int KfW        = 24;

  localparam int NewtonStepsDef = 4;

  localparam logic [PlatoW-1:0] PlatoMax = 16'd40960;
  localparam logic [GravW-1:0]  GravMax  = 21'h1FFFFF;
  localparam logic [SgW-1:0]    SgOne    = 26'h1000000;
  localparam logic [SgW-1:0]    SgMax    = 26'h2000000;

  // Q24 constants, rounded to nearest at elaboration
  localparam longint unsigned KGuessBase  = (64'd2586 * 64'd16777216 + 64'd5) / 64'd10;
  localparam longint unsigned KGuessRatio = (64'd2271 * 64'd16777216 + 64'd1291) / 64'd2582;
  localparam longint unsigned KF0 = (64'd616868 * 64'd16777216 + 64'd500) / 64'd1000;
  localparam longint unsigned KF1 = (64'd111114 * 64'd16777216 + 64'd50) / 64'd100;
  localparam longint unsigned KF2 = (64'd630272 * 64'd16777216 + 64'd500) / 64'd1000;
  localparam longint unsigned KF3 = (64'd135997 * 64'd16777216 + 64'd500) / 64'd1000;
  localparam longint unsigned KD1 = (64'd1260544 * 64'd16777216 + 64'd500) / 64'd1000;
  localparam longint unsigned KD2 = (64'd407991 * 64'd16777216 + 64'd500) / 64'd1000;

  // integer / fraction split so each product stays narrow
  localparam logic [KiW-1:0] KF1I = KiW'(KF1 >> 24);
  localparam logic [KfW-1:0] KF1F = KfW'(KF1);
  localparam logic [KiW-1:0] KF2I = KiW'(KF2 >> 24);
  localparam logic [KfW-1:0] KF2F = KfW'(KF2);
  localparam logic [KiW-1:0] KF3I = KiW'(KF3 >> 24);
  localparam logic [KfW-1:0] KF3F = KfW'(KF3);
  localparam logic [KiW-1:0] KD1I = KiW'(KD1 >> 24);
  localparam logic [KfW-1:0] KD1F = KfW'(KD1);
  localparam logic [KiW-1:0] KD2I = KiW'(KD2 >> 24);
  localparam logic [KfW-1:0] KD2F = KfW'(KD2);

  // floor(K * x / 2^24) with K = ki*2^24 + kf
  function automatic logic [MulW-1:0] qmulk(input logic [KiW-1:0] ki,
                                            input logic [KfW-1:0] kf,
                                            input logic [S3W-1:0] x);
    logic [KfW+S3W-1:0] lo;
    lo = (KfW+S3W)'(kf) * (KfW+S3W)'(x);
    return MulW'(ki) * MulW'(x) + MulW'(lo >> FracW);
  endfunction

endpackage

### hw/rtl/p2sg_div.sv
module p2sg_div #(
  parameter int NUM_W = 59,
  parameter int DEN_W = 36,
  parameter int QUO_W = 27,
  parameter int TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  // one quotient bit per stage; low_q shifts numerator bits out, quotient bits in
  logic             vld_q [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] low_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = DEN_W'(num_i >> QUO_W);
      assign den_in = den_i;
      assign low_in = QUO_W'(num_i);
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        den_q[k] <= den_in;
        low_q[k] <= {low_in[QUO_W-2:0], ge};
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = low_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule

### hw/rtl/plato_to_specific_gravity.sv
// Throughput: one transaction per cycle while the output is not stalled; every stage is registered,
// the pipelined dividers (23 stages for the first guess, 27 in each Newton step) set the depth.
// Stall: the whole pipeline holds while the output register is full and not taken.
// Reset: rst_ni, asynchronous, active low, clears all valid bits; data registers are not reset.
module plato_to_specific_gravity #(
  parameter int NEWTON_STEPS = p2sg_pkg::NewtonStepsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [p2sg_pkg::PlatoW-1:0]      s_axis_tdata_i,  // [15:0] plato
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [p2sg_pkg::OutTdataW-1:0]   m_axis_tdata_o   // [20:0] gravity, [23:21] zero
);
  import p2sg_pkg::*;

  // single advance enable: everything moves unless the output register is blocked
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------------------------------------------------------------------
  // First guess: SG0 = 1 + P / (258.6 - P * 227.1/258.2)
  // ---------------------------------------------------------------------------
  logic                 g1_vld_q, g2_vld_q, g3_vld_q, g4_vld_q;
  logic [PlatoW-1:0]    g1_raw_q, g2_raw_q, g3_raw_q, g4_raw_q;
  logic [GuessDenW-1:0] g2_prod_q, g3_den_q;
  logic [SgW-1:0]       g4_s_q;
  logic [PlatoW+KfW-1:0] g_prod_full;
  logic                 gdiv_vld;
  logic [GuessQuoW-1:0] gdiv_quo;
  logic [PlatoW-1:0]    gdiv_raw;
  logic [SgW:0]         g_sum;

  // P * ratio in Q24: (raw << 14) * K >> 24 == raw * K >> 10
  assign g_prod_full = (PlatoW+KfW)'(g1_raw_q) * (PlatoW+KfW)'(KGuessRatio);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
      g3_vld_q <= 1'b0;
      g4_vld_q <= 1'b0;
    end else if (adv) begin
      g1_vld_q <= s_axis_tvalid_i;
      g2_vld_q <= g1_vld_q;
      g3_vld_q <= g2_vld_q;
      g4_vld_q <= gdiv_vld;
    end
  end

  assign g_sum = (SgW+1)'(SgOne) + (SgW+1)'(gdiv_quo);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_raw_q  <= (s_axis_tdata_i > PlatoMax) ? PlatoMax : s_axis_tdata_i;
      g2_raw_q  <= g1_raw_q;
      g2_prod_q <= GuessDenW'(g_prod_full >> 10);
      g3_raw_q  <= g2_raw_q;
      g3_den_q  <= GuessDenW'(KGuessBase) - g2_prod_q;
      g4_raw_q  <= gdiv_raw;
      g4_s_q    <= (g_sum > (SgW+1)'(SgMax)) ? SgMax : SgW'(g_sum);
    end
  end

  p2sg_div #(
    .NUM_W (GuessNumW),
    .DEN_W (GuessDenW),
    .QUO_W (GuessQuoW),
    .TAG_W (PlatoW)
  ) u_guess_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g3_vld_q),
    .num_i   ({g3_raw_q, 38'd0}),
    .den_i   (g3_den_q),
    .tag_i   (g3_raw_q),
    .valid_o (gdiv_vld),
    .quo_o   (gdiv_quo),
    .tag_o   (gdiv_raw)
  );

  // ---------------------------------------------------------------------------
  // Newton steps, unrolled: s <- s - f(s) / f'(s)
  // ---------------------------------------------------------------------------
  logic              vld_c [NEWTON_STEPS+1];
  logic [SgW-1:0]    s_c   [NEWTON_STEPS+1];
  logic [PlatoW-1:0] raw_c [NEWTON_STEPS+1];

  assign vld_c[0] = g4_vld_q;
  assign s_c[0]   = g4_s_q;
  assign raw_c[0] = g4_raw_q;

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    logic              n1_vld_q, n2_vld_q, n3_vld_q, n4_vld_q, n5_vld_q;
    logic [SgW-1:0]    n1_s_q, n2_s_q, n3_s_q, n4_s_q, n5_s_q;
    logic [PlatoW-1:0] n1_raw_q, n2_raw_q, n3_raw_q, n5_raw_q;
    logic [S2W-1:0]    n1_s2_q;
    logic [S3W-1:0]    n2_s3_q;
    logic [MulW-1:0]   n1_a1_q, n1_b1_q, n2_a1_q, n2_b1_q, n2_a2_q, n2_b2_q;
    logic [MulW-1:0]   n3_a1_q, n3_a2_q, n3_a3_q;
    logic [DenW-1:0]   n3_d_q, n4_d_q;
    logic signed [AccW-1:0] n4_f_q;
    logic [2*SgW-1:0]  sq_full;
    logic [S2W+SgW-1:0] cube_full;
    logic signed [AccW-1:0] dsum, fsum, fabs;
    logic              fneg;
    logic              div_vld;
    logic [NewtonQuoW-1:0] div_quo;
    logic [SgW:0]      div_tag;
    logic [PlatoW-1:0] div_raw;
    logic signed [SgW+2:0] qs, sn;

    assign sq_full   = (2*SgW)'(s_c[k]) * (2*SgW)'(s_c[k]);
    assign cube_full = (S2W+SgW)'(n1_s2_q) * (S2W+SgW)'(n1_s_q);

    // f'(s) is at least about 137 on [0, 2]; guard anyway
    assign dsum = AccW'(KF1) - AccW'(n2_b1_q) + AccW'(n2_b2_q);

    assign fsum = -AccW'(KF0) + AccW'(n3_a1_q) - AccW'(n3_a2_q) + AccW'(n3_a3_q)
                  - AccW'({n3_raw_q, 14'd0});

    assign fneg = n4_f_q[AccW-1];
    assign fabs = fneg ? -n4_f_q : n4_f_q;

    assign qs = div_tag[0] ? -(SgW+3)'(div_quo) : (SgW+3)'(div_quo);
    assign sn = (SgW+3)'(div_tag[SgW:1]) - qs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        n1_vld_q <= 1'b0;
        n2_vld_q <= 1'b0;
        n3_vld_q <= 1'b0;
        n4_vld_q <= 1'b0;
        n5_vld_q <= 1'b0;
      end else if (adv) begin
        n1_vld_q <= vld_c[k];
        n2_vld_q <= n1_vld_q;
        n3_vld_q <= n2_vld_q;
        n4_vld_q <= n3_vld_q;
        n5_vld_q <= div_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n1_s_q   <= s_c[k];
        n1_raw_q <= raw_c[k];
        n1_s2_q  <= S2W'(sq_full >> FracW);
        n1_a1_q  <= qmulk(KF1I, KF1F, S3W'(s_c[k]));
        n1_b1_q  <= qmulk(KD1I, KD1F, S3W'(s_c[k]));

        n2_s_q   <= n1_s_q;
        n2_raw_q <= n1_raw_q;
        n2_s3_q  <= S3W'(cube_full >> FracW);
        n2_a1_q  <= n1_a1_q;
        n2_b1_q  <= n1_b1_q;
        n2_a2_q  <= qmulk(KF2I, KF2F, S3W'(n1_s2_q));
        n2_b2_q  <= qmulk(KD2I, KD2F, S3W'(n1_s2_q));

        n3_s_q   <= n2_s_q;
        n3_raw_q <= n2_raw_q;
        n3_a1_q  <= n2_a1_q;
        n3_a2_q  <= n2_a2_q;
        n3_a3_q  <= qmulk(KF3I, KF3F, n2_s3_q);
        n3_d_q   <= (dsum <= 0) ? DenW'(1) : DenW'(dsum);

        n4_s_q   <= n3_s_q;
        n4_d_q   <= n3_d_q;
        n4_f_q   <= fsum;

        n5_raw_q <= div_raw;
        if (sn < 0) begin
          n5_s_q <= '0;
        end else if (sn > (SgW+3)'(SgMax)) begin
          n5_s_q <= SgMax;
        end else begin
          n5_s_q <= SgW'(sn);
        end
      end
    end

    // raw rides alongside the divider in a plain delay line
    logic [PlatoW-1:0] raw_dl_q [NewtonQuoW+1];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        raw_dl_q[0] <= n3_raw_q;
        for (int j = 1; j <= NewtonQuoW; j++) begin
          raw_dl_q[j] <= raw_dl_q[j-1];
        end
      end
    end
    assign div_raw = raw_dl_q[NewtonQuoW];

    p2sg_div #(
      .NUM_W (NumW),
      .DEN_W (DenW),
      .QUO_W (NewtonQuoW),
      .TAG_W (SgW+1)
    ) u_step_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (n4_vld_q),
      .num_i   ({FmagW'(fabs), {FracW{1'b0}}}),
      .den_i   (n4_d_q),
      .tag_i   ({n4_s_q, fneg}),
      .valid_o (div_vld),
      .quo_o   (div_quo),
      .tag_o   (div_tag)
    );

    assign vld_c[k+1] = n5_vld_q;
    assign s_c[k+1]   = n5_s_q;
    assign raw_c[k+1] = n5_raw_q;
  end

  // ---------------------------------------------------------------------------
  // Output register: Q24 -> Q20 with rounding, saturate at the 21-bit maximum, just under 2.0
  // ---------------------------------------------------------------------------
  logic             out_vld_q;
  logic [GravW-1:0] out_grav_q;
  logic [SgW-1:0]   s_fin;
  logic [SgW:0]     s_rnd;

  assign s_fin = s_c[NEWTON_STEPS];
  assign s_rnd = ((SgW+1)'(s_fin) + (SgW+1)'(8)) >> 4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_c[NEWTON_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_grav_q <= (s_rnd > (SgW+1)'(GravMax)) ? GravMax : GravW'(s_rnd);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW-GravW){1'b0}}, out_grav_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not track output stall");

  a_guess_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g4_vld_q |-> (g4_s_q >= SgOne) && (g4_s_q <= SgMax))
    else $error("first guess outside [1, 2]");

  a_final_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[NEWTON_STEPS] |-> (s_c[NEWTON_STEPS] <= SgMax))
    else $error("refined estimate above 2.0");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(out_grav_q) && $stable(g1_raw_q))
    else $error("pipeline moved during stall");

endmodule

### tb/plato_to_specific_gravity_tb.sv
module plato_to_specific_gravity_tb;
  import p2sg_pkg::*;

  // Newton refinement depth used by the instance and by the predictor
  localparam int Steps = NewtonStepsDef;

  // Q24 constants, rounded to nearest
  localparam longint QOne       = 64'd16777216;
  localparam longint QGuessBase = (64'd2586 * QOne + 64'd5) / 64'd10;
  localparam longint QGuessRat  = (64'd2271 * QOne + 64'd1291) / 64'd2582;
  localparam longint QF0        = (64'd616868 * QOne + 64'd500) / 64'd1000;
  localparam longint QF1        = (64'd111114 * QOne + 64'd50) / 64'd100;
  localparam longint QF2        = (64'd630272 * QOne + 64'd500) / 64'd1000;
  localparam longint QF3        = (64'd135997 * QOne + 64'd500) / 64'd1000;
  localparam longint QD1        = (64'd1260544 * QOne + 64'd500) / 64'd1000;
  localparam longint QD2        = (64'd407991 * QOne + 64'd500) / 64'd1000;
  localparam longint QSgTop     = 2 * QOne;

  // 28 + 32 * steps pipeline stages, plus margin
  localparam int DrainCycles = 28 + 32 * Steps + 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [PlatoW-1:0]    s_axis_tdata_i;     // [15:0] plato
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;     // [20:0] gravity, [23:21] zero

  plato_to_specific_gravity #(
    .NEWTON_STEPS(Steps)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // expected gravity words, oldest first
  logic [OutTdataW-1:0] gravity_q[$];
  int                   err_cnt;

  // idle / stall percentages for the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // long receiver hold-off, counted down in the receiver process
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // product of two non-negative Q24 values, floored
  function automatic longint q24_mul(input longint a, input longint b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return longint'(prod >> 24);
  endfunction

  function automatic longint sg_clamp(input longint s);
    if (s < 0) return 0;
    if (s > QSgTop) return QSgTop;
    return s;
  endfunction

  // Plato reading -> expected output tdata word
  function automatic logic [OutTdataW-1:0] predict_gravity(input logic [PlatoW-1:0] plato);
    longint p, den, sg, sg2, sg3, fval, dval;
    longint unsigned g;
    p   = (plato > PlatoMax) ? longint'(PlatoMax) : longint'(plato);
    p   = p << 14;
    den = QGuessBase - q24_mul(p, QGuessRat);
    sg  = sg_clamp(QOne + (p * QOne) / den);
    for (int i = 0; i < Steps; i++) begin
      sg2  = q24_mul(sg, sg);
      sg3  = q24_mul(sg2, sg);
      fval = -QF0 + q24_mul(QF1, sg) - q24_mul(QF2, sg2) + q24_mul(QF3, sg3) - p;
      dval = QF1 - q24_mul(QD1, sg) + q24_mul(QD2, sg2);
      if (dval <= 0) dval = 1;
      sg = sg_clamp(sg - (fval * QOne) / dval);
    end
    g = (longint'(sg) + 8) >> 4;
    if (g > GravMax) g = GravMax;
    return OutTdataW'(g);
  endfunction

  // receiver: random stall plus optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles     <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [OutTdataW-1:0] exp_word;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (gravity_q.size() == 0) begin
        $display("%0t: unexpected gravity transaction, actual %h", $time, m_axis_tdata_o);
        err_cnt++;
      end else begin
        exp_word = gravity_q.pop_front();
        if (m_axis_tdata_o !== exp_word) begin
          $display("%0t: gravity expected %h actual %h", $time, exp_word, m_axis_tdata_o);
          err_cnt++;
        end
      end
    end
  end

  // offer one reading; returns once the transaction is accepted, tvalid left high
  task automatic send_plato(input logic [PlatoW-1:0] plato);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= plato;
    do @(posedge clk_i); while (!s_axis_tready_o);
    gravity_q.push_back(predict_gravity(plato));
  endtask

  task automatic test_directed();
    logic [PlatoW-1:0] pts[$];
    pts = {16'd0, 16'd1, 16'd1024, 16'd10240, 16'd20480, 16'd30720,
           16'd40959, 16'd40960, 16'd40961, 16'd32768, 16'h7FFF, 16'h8000,
           16'hAAAA, 16'h5555, 16'hFFFE, 16'hFFFF, 16'd512, 16'd12288};
    foreach (pts[i]) send_plato(pts[i]);
  endtask

  // mostly in-range readings, some above range
  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_plato(($urandom_range(9) == 0) ? PlatoW'($urandom)
                                          : PlatoW'($urandom_range(40960)));
  endtask

  // receiver blocks long enough to fill the pipeline while input keeps coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    test_random(300);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (gravity_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    err_cnt         = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(400);
    send_idle_pct = 60; recv_stall_pct = 0;  test_random(350);
    send_idle_pct = 0;  recv_stall_pct = 60; test_random(350);
    send_idle_pct = 8;  recv_stall_pct = 8;  test_random(480);
    test_backpressure();

    wait_drained();
    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
